FILE: sv/mips_pkg.sv
// MIPS integer execute unit package: payload structs, command codes, constants.
// No dependencies.
`timescale 1ns / 1ps
package mips_pkg;

  localparam int unsigned MemBytes = 65536;
  localparam int unsigned MemAw = $clog2(MemBytes);
  localparam logic [31:0] BaseReset = 32'h0040_0000;
  localparam logic [31:0] SegMask = 32'hf000_0000;
  localparam logic [31:0] SignBit = 32'h8000_0000;

  typedef enum logic [5:0] {
    OpAdd, OpAddu, OpAnd, OpDiv, OpDivu, OpJalr, OpJr, OpMfhi, OpMflo,
    OpMthi, OpMtlo, OpMult, OpMultu, OpNor, OpOr, OpSll, OpSllv,
    OpSlt, OpSltu, OpSra, OpSrav, OpSrl, OpSrlv, OpSub, OpSubu,
    OpXor, OpAddi, OpAddiu, OpAndi, OpBeq, OpBgez, OpBgtz, OpBlez,
    OpBltz, OpBne, OpLb, OpLbu, OpLh, OpLhu, OpLui, OpLw, OpOri,
    OpSb, OpSlti, OpSltiu, OpSh, OpSw, OpXori, OpLwl, OpLwr, OpSwl,
    OpSwr, OpJ, OpJal
  } op_e;

  localparam logic [1:0] FaultNone = 2'd0;
  localparam logic [1:0] FaultAddr = 2'd1;
  localparam logic [1:0] FaultDiv  = 2'd2;

  typedef struct packed {
    logic [5:0]  command;
    logic [4:0]  src_reg;
    logic [4:0]  second_reg;
    logic [4:0]  dest_reg;
    logic [4:0]  shift_amount;
    logic [15:0] immediate;
    logic [25:0] jump_target;
  } instr_t;

  typedef struct packed {
    logic [31:0] next_pc;
    logic [4:0]  written_index;
    logic [31:0] written_value;
    logic        did_write;
    logic [31:0] hi_value;
    logic [31:0] lo_value;
    logic [1:0]  fault;
  } result_t;

endpackage

FILE: sv/mips_integer_execute_unit_core.sv
// MIPS32 integer execute unit, top level: instruction queue in front of the execute back end.
// Depends on mips_pkg, mips_inq, mips_exec.
// Instructions enter a two-entry queue and execute one at a time. ALU, branch and jump
// instructions pass the execute and done states; a load or store adds a memory state (the
// synchronous four-lane byte memory; skipped when the address faults), a multiply a state
// for the product, a divide a divide state (32-step radix-2 divider; not on a zero divisor).
// A finished result is held in an output register; the next instruction starts once it is taken.
`timescale 1ns / 1ps
module mips_integer_execute_unit_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  mips_pkg::instr_t  data_i,
  output logic              empty,
  input  logic              pop,
  output mips_pkg::result_t data_o,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_data_i
);
  logic q_empty, q_pop, res_v, busy;
  mips_pkg::instr_t q_data;

  mips_inq u_inq (
    .clk_i, .rst_ni, .push_i(push), .data_i, .full_o(full),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(q_data)
  );

  mips_exec u_exec (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_data_i,
    .ins_valid_i(!q_empty), .ins_i(q_data), .ins_pop_o(q_pop),
    .res_valid_o(res_v), .res_o(data_o), .res_pop_i(pop), .busy_o(busy)
  );

  assign empty = !res_v;

  a_nowrite_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (data_o.did_write || (data_o.written_index == 5'd0 &&
                data_o.written_value == 32'd0)))
    else $error("write fields nonzero without write");
  a_fault_nowrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && data_o.fault != mips_pkg::FaultNone) |-> !data_o.did_write)
    else $error("faulting instruction wrote a register");
  a_no_start_while_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_v && !pop) |=> !$rose(busy))
    else $error("execution started while result waits");
endmodule

FILE: sv/mips_inq.sv
// MIPS execute unit front: two-entry instruction queue between acceptance and execution.
// Depends on mips_pkg.
`timescale 1ns / 1ps
module mips_inq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mips_pkg::instr_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output mips_pkg::instr_t data_o
);
  mips_pkg::instr_t mem_q [2];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;
  logic do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = mem_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0;
      rp_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (do_push) wp_q <= ~wp_q;
      if (do_pop) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end
endmodule

FILE: sv/mips_div.sv
// MIPS execute unit: radix-2 restoring divider, signed or unsigned.
// Depends on nothing else.
`timescale 1ns / 1ps
module mips_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic        sgn_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [31:0] quo_o,
  output logic [31:0] rem_o
);
  logic        busy_q;
  logic [4:0]  cnt_q;
  logic [31:0] q_q, r_q, d_q;
  logic        negq_q, negr_q;
  logic [32:0] trial;
  logic [31:0] r_sh;
  logic [31:0] ua, ub;

  assign ua = (sgn_i && a_i[31]) ? 32'd0 - a_i : a_i;
  assign ub = (sgn_i && b_i[31]) ? 32'd0 - b_i : b_i;
  assign r_sh = {r_q[30:0], q_q[31]};
  assign trial = {r_q, q_q[31]} - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      cnt_q <= 5'd0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= ua;
      r_q <= 32'd0;
      d_q <= ub;
      negq_q <= sgn_i && (a_i[31] ^ b_i[31]);
      negr_q <= sgn_i && a_i[31];
    end else if (busy_q) begin
      if (!trial[32]) begin
        r_q <= trial[31:0];
        q_q <= {q_q[30:0], 1'b1};
      end else begin
        r_q <= r_sh;
        q_q <= {q_q[30:0], 1'b0};
      end
    end
  end

  assign quo_o = negq_q ? 32'd0 - q_q : q_q;
  assign rem_o = negr_q ? 32'd0 - r_q : r_q;
endmodule

FILE: sv/mips_exec.sv
// MIPS execute unit back end: register file, HI/LO, PC, byte memory and sequencer.
// Depends on mips_pkg and mips_div.
`timescale 1ns / 1ps
module mips_exec (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [31:0]      cfg_data_i,
  input  logic             ins_valid_i,
  input  mips_pkg::instr_t ins_i,
  output logic             ins_pop_o,
  output logic             res_valid_o,
  output mips_pkg::result_t res_o,
  input  logic             res_pop_i,
  output logic             busy_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StExec = 3'd1;
  localparam logic [2:0] StMem  = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StDone = 3'd5;
  localparam int unsigned Aw = mips_pkg::MemAw;

  logic [2:0] st_q, st_d;
  logic [31:0] regs_q [32];
  logic [31:0] hi_q, lo_q, pc_q, base_q;
  logic [7:0] mem0_q [mips_pkg::MemBytes/4];
  logic [7:0] mem1_q [mips_pkg::MemBytes/4];
  logic [7:0] mem2_q [mips_pkg::MemBytes/4];
  logic [7:0] mem3_q [mips_pkg::MemBytes/4];
  logic [7:0] rd_q [4];
  mips_pkg::instr_t ins_q;
  logic [31:0] a_q, b_q;
  logic res_v_q;
  mips_pkg::result_t res_q;
  logic [63:0] prod_q;

  mips_pkg::op_e op;
  logic [31:0] simm, ea, off, pc4, btgt;
  logic [2:0] nbytes;
  logic [31:0] first;
  logic [1:0] k;
  logic range_ok;
  logic is_load, is_store;
  logic [Aw-1:0] bidx [4];
  logic [3:0] bact;
  logic [7:0] bdat [4];
  logic [1:0] lane [4];
  logic [Aw-3:0] row [4];
  logic [31:0] ld;

  logic div_start, div_done;
  logic [31:0] quo, rem;

  assign op = mips_pkg::op_e'(ins_q.command);
  assign simm = {{16{ins_q.immediate[15]}}, ins_q.immediate};
  assign ea = a_q + simm;
  assign off = ea - base_q;
  assign k = ea[1:0];
  assign pc4 = pc_q + 32'd4;
  assign btgt = pc4 + {simm[29:0], 2'b00};

  always_comb begin
    is_load = 1'b0;
    is_store = 1'b0;
    nbytes = 3'd1;
    first = off;
    case (op)
      mips_pkg::OpLb, mips_pkg::OpLbu: is_load = 1'b1;
      mips_pkg::OpLh, mips_pkg::OpLhu: begin is_load = 1'b1; nbytes = 3'd2; end
      mips_pkg::OpLw: begin is_load = 1'b1; nbytes = 3'd4; end
      mips_pkg::OpSb: is_store = 1'b1;
      mips_pkg::OpSh: begin is_store = 1'b1; nbytes = 3'd2; end
      mips_pkg::OpSw: begin is_store = 1'b1; nbytes = 3'd4; end
      mips_pkg::OpLwl, mips_pkg::OpSwl: begin
        is_load = op == mips_pkg::OpLwl;
        is_store = op == mips_pkg::OpSwl;
        nbytes = {1'b0, k} + 3'd1;
        first = off - {30'd0, k};
      end
      mips_pkg::OpLwr, mips_pkg::OpSwr: begin
        is_load = op == mips_pkg::OpLwr;
        is_store = op == mips_pkg::OpSwr;
        nbytes = 3'd4 - {1'b0, k};
      end
      default: ;
    endcase
  end

  always_comb begin
    range_ok = first < 32'(mips_pkg::MemBytes) &&
               32'(nbytes) <= 32'(mips_pkg::MemBytes) - first;
    if ((op == mips_pkg::OpLwl || op == mips_pkg::OpSwl) && off < {30'd0, k})
      range_ok = 1'b0;
  end

  // byte j of the access is at first+j; value byte slot depends on op
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      bidx[j] = first[Aw-1:0] + Aw'(j);
      bact[j] = 3'(j) < nbytes;
      lane[j] = bidx[j][1:0];
      row[j]  = bidx[j][Aw-1:2];
      bdat[j] = b_q[8*j +: 8];
    end
    if (op == mips_pkg::OpSwl) begin
      for (int j = 0; j < 4; j++)
        if (3'(j) < nbytes) bdat[j] = b_q[8*(3 - int'(k) + j) +: 8];
    end
  end

  // map lane -> byte slot for the memory write
  logic [3:0] lwe;
  logic [Aw-3:0] lrow [4];
  logic [7:0] ldat [4];
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      lwe[l] = 1'b0;
      lrow[l] = row[0];
      ldat[l] = 8'd0;
      for (int j = 0; j < 4; j++) begin
        if (bact[j] && lane[j] == 2'(l)) begin
          lwe[l] = 1'b1;
          lrow[l] = row[j];
          ldat[l] = bdat[j];
        end
      end
    end
  end

  logic mem_go;
  assign mem_go = st_q == StExec && (is_load || is_store) && range_ok;

  always_ff @(posedge clk_i) begin
    if (mem_go) begin
      if (is_store && lwe[0]) mem0_q[lrow[0]] <= ldat[0];
      if (is_store && lwe[1]) mem1_q[lrow[1]] <= ldat[1];
      if (is_store && lwe[2]) mem2_q[lrow[2]] <= ldat[2];
      if (is_store && lwe[3]) mem3_q[lrow[3]] <= ldat[3];
      rd_q[0] <= mem0_q[lrow[0]];
      rd_q[1] <= mem1_q[lrow[1]];
      rd_q[2] <= mem2_q[lrow[2]];
      rd_q[3] <= mem3_q[lrow[3]];
    end
  end

  // reassemble in access order
  logic [7:0] lb [4];
  always_comb begin
    for (int j = 0; j < 4; j++) lb[j] = rd_q[lane[j]];
    ld = b_q;
    case (op)
      mips_pkg::OpLb:  ld = {{24{lb[0][7]}}, lb[0]};
      mips_pkg::OpLbu: ld = {24'd0, lb[0]};
      mips_pkg::OpLh:  ld = {{16{lb[1][7]}}, lb[1], lb[0]};
      mips_pkg::OpLhu: ld = {16'd0, lb[1], lb[0]};
      mips_pkg::OpLw:  ld = {lb[3], lb[2], lb[1], lb[0]};
      mips_pkg::OpLwl: begin
        for (int j = 0; j < 4; j++)
          if (3'(j) < nbytes) ld[8*(3 - int'(k) + j) +: 8] = lb[j];
      end
      mips_pkg::OpLwr: begin
        for (int j = 0; j < 4; j++)
          if (3'(j) < nbytes) ld[8*j +: 8] = lb[j];
      end
      default: ;
    endcase
  end

  mips_div u_div (
    .clk_i, .rst_ni,
    .start_i(div_start), .sgn_i(op == mips_pkg::OpDiv),
    .a_i(a_q), .b_i(b_q),
    .done_o(div_done), .quo_o(quo), .rem_o(rem)
  );

  logic is_div, is_mul;
  assign is_div = op == mips_pkg::OpDiv || op == mips_pkg::OpDivu;
  assign is_mul = op == mips_pkg::OpMult || op == mips_pkg::OpMultu;
  assign div_start = st_q == StExec && is_div && b_q != 32'd0;

  // ALU and write-back decision
  logic wr;
  logic [4:0] widx;
  logic [31:0] wval, npc, nhi, nlo;
  logic [1:0] flt;
  logic [4:0] sv;
  logic sgn_m;
  assign sv = a_q[4:0];
  assign sgn_m = op == mips_pkg::OpMult;

  always_comb begin
    wr = 1'b0;
    widx = ins_q.dest_reg;
    wval = 32'd0;
    npc = pc4;
    nhi = hi_q;
    nlo = lo_q;
    flt = mips_pkg::FaultNone;
    unique case (op)
      mips_pkg::OpAdd, mips_pkg::OpAddu: begin wr = 1'b1; wval = a_q + b_q; end
      mips_pkg::OpAnd: begin wr = 1'b1; wval = a_q & b_q; end
      mips_pkg::OpDiv, mips_pkg::OpDivu: begin
        if (b_q == 32'd0) flt = mips_pkg::FaultDiv;
        else begin nhi = rem; nlo = quo; end
      end
      mips_pkg::OpJalr: begin wr = 1'b1; wval = pc4; npc = a_q; end
      mips_pkg::OpJr: npc = a_q;
      mips_pkg::OpMfhi: begin wr = 1'b1; wval = hi_q; end
      mips_pkg::OpMflo: begin wr = 1'b1; wval = lo_q; end
      mips_pkg::OpMthi: nhi = a_q;
      mips_pkg::OpMtlo: nlo = a_q;
      mips_pkg::OpMult, mips_pkg::OpMultu: begin
        nhi = prod_q[63:32]; nlo = prod_q[31:0];
      end
      mips_pkg::OpNor: begin wr = 1'b1; wval = ~(a_q | b_q); end
      mips_pkg::OpOr: begin wr = 1'b1; wval = a_q | b_q; end
      mips_pkg::OpSll: begin wr = 1'b1; wval = b_q << ins_q.shift_amount; end
      mips_pkg::OpSllv: begin wr = 1'b1; wval = b_q << sv; end
      mips_pkg::OpSlt: begin wr = 1'b1; wval = {31'd0, $signed(a_q) < $signed(b_q)}; end
      mips_pkg::OpSltu: begin wr = 1'b1; wval = {31'd0, a_q < b_q}; end
      mips_pkg::OpSra: begin
        wr = 1'b1; wval = 32'($signed(b_q) >>> ins_q.shift_amount);
      end
      mips_pkg::OpSrav: begin wr = 1'b1; wval = 32'($signed(b_q) >>> sv); end
      mips_pkg::OpSrl: begin wr = 1'b1; wval = b_q >> ins_q.shift_amount; end
      mips_pkg::OpSrlv: begin wr = 1'b1; wval = b_q >> sv; end
      mips_pkg::OpSub, mips_pkg::OpSubu: begin wr = 1'b1; wval = a_q - b_q; end
      mips_pkg::OpXor: begin wr = 1'b1; wval = a_q ^ b_q; end
      mips_pkg::OpAddi, mips_pkg::OpAddiu: begin
        wr = 1'b1; widx = ins_q.second_reg; wval = a_q + simm;
      end
      mips_pkg::OpAndi: begin
        wr = 1'b1; widx = ins_q.second_reg; wval = a_q & {16'd0, ins_q.immediate};
      end
      mips_pkg::OpOri: begin
        wr = 1'b1; widx = ins_q.second_reg; wval = a_q | {16'd0, ins_q.immediate};
      end
      mips_pkg::OpXori: begin
        wr = 1'b1; widx = ins_q.second_reg; wval = a_q ^ {16'd0, ins_q.immediate};
      end
      mips_pkg::OpBeq: if (a_q == b_q) npc = btgt;
      mips_pkg::OpBne: if (a_q != b_q) npc = btgt;
      mips_pkg::OpBgez: if (!a_q[31]) npc = btgt;
      mips_pkg::OpBgtz: if (!a_q[31] && a_q != 32'd0) npc = btgt;
      mips_pkg::OpBlez: if (a_q[31] || a_q == 32'd0) npc = btgt;
      mips_pkg::OpBltz: if (a_q[31]) npc = btgt;
      mips_pkg::OpLui: begin
        wr = 1'b1; widx = ins_q.second_reg; wval = {ins_q.immediate, 16'd0};
      end
      mips_pkg::OpSlti: begin
        wr = 1'b1; widx = ins_q.second_reg;
        wval = {31'd0, $signed(a_q) < $signed(simm)};
      end
      mips_pkg::OpSltiu: begin
        wr = 1'b1; widx = ins_q.second_reg; wval = {31'd0, a_q < simm};
      end
      mips_pkg::OpLb, mips_pkg::OpLbu, mips_pkg::OpLh, mips_pkg::OpLhu,
      mips_pkg::OpLw, mips_pkg::OpLwl, mips_pkg::OpLwr: begin
        widx = ins_q.second_reg;
        if (!range_ok) flt = mips_pkg::FaultAddr;
        else begin wr = 1'b1; wval = ld; end
      end
      mips_pkg::OpSb, mips_pkg::OpSh, mips_pkg::OpSw, mips_pkg::OpSwl,
      mips_pkg::OpSwr: if (!range_ok) flt = mips_pkg::FaultAddr;
      mips_pkg::OpJ: npc = (pc4 & mips_pkg::SegMask) | {4'd0, ins_q.jump_target, 2'b00};
      mips_pkg::OpJal: begin
        wr = 1'b1; widx = 5'd31; wval = pc4;
        npc = (pc4 & mips_pkg::SegMask) | {4'd0, ins_q.jump_target, 2'b00};
      end
      default: ;
    endcase
    if (!wr || widx == 5'd0) begin
      wr = 1'b0; widx = 5'd0; wval = 32'd0;
    end
  end

  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StIdle: if (ins_valid_i && !res_v_q) st_d = StExec;
      StExec: begin
        if (div_start) st_d = StDiv;
        else if (is_mul) st_d = StMul;
        else if ((is_load || is_store) && range_ok) st_d = StMem;
        else st_d = StDone;
      end
      StDiv: if (div_done) st_d = StDone;
      StMem, StMul: st_d = StDone;
      StDone: st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  assign ins_pop_o = st_q == StIdle && ins_valid_i && !res_v_q;
  assign busy_o = st_q != StIdle;

  always_ff @(posedge clk_i) begin
    if (ins_pop_o) ins_q <= ins_i;
    if (ins_pop_o) begin
      a_q <= ins_i.src_reg == 5'd0 ? 32'd0 : regs_q[ins_i.src_reg];
      b_q <= ins_i.second_reg == 5'd0 ? 32'd0 : regs_q[ins_i.second_reg];
    end
    if (st_q == StExec && is_mul)
      prod_q <= 64'($signed({sgn_m && a_q[31], a_q}) * $signed({sgn_m && b_q[31], b_q}));
    if (st_q == StDone) res_q <= '{npc, widx, wval, wr, nhi, nlo, flt};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      res_v_q <= 1'b0;
      hi_q <= 32'd0;
      lo_q <= 32'd0;
      base_q <= mips_pkg::BaseReset;
      pc_q <= mips_pkg::BaseReset;
      for (int i = 0; i < 32; i++) regs_q[i] <= 32'd0;
    end else begin
      st_q <= st_d;
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
        pc_q <= cfg_data_i;
      end
      if (st_q == StDone) begin
        res_v_q <= 1'b1;
        pc_q <= npc;
        hi_q <= nhi;
        lo_q <= nlo;
        if (wr) regs_q[widx] <= wval;
      end else if (res_pop_i && res_v_q) begin
        res_v_q <= 1'b0;
      end
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o = res_q;
endmodule

FILE: test/mips_integer_execute_unit_core_tb.sv
// Testbench for mips_integer_execute_unit_core: directed and random instruction streams,
// checked against an in-bench execute model. Depends on mips_pkg and the core.
`timescale 1ns / 1ps
module mips_integer_execute_unit_core_tb;

  localparam int CycleLimit = 600000;
  localparam logic [4:0] PtrReg = 5'd28;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic push, full, empty, pop;
  mips_pkg::instr_t data_i;
  mips_pkg::result_t data_o;
  logic cfg_we_i;
  logic [31:0] cfg_data_i;

  // execute model state
  logic [31:0] gpr [32];
  logic [31:0] hi_q, lo_q, pc_q, base_q;
  logic [7:0] mem_q [mips_pkg::MemBytes];
  bit written_q [mips_pkg::MemBytes];

  mips_pkg::result_t pending_results[$];
  int errors = 0;
  int cycles = 0;
  bit calm = 0;

  mips_integer_execute_unit_core DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .push(push), .full(full), .data_i(data_i),
    .empty(empty), .pop(pop), .data_o(data_o),
    .cfg_we_i(cfg_we_i), .cfg_data_i(cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t timeout", $time);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [31:0] rd_reg(logic [4:0] r);
    return (r == 0) ? 32'd0 : gpr[r];
  endfunction

  function automatic bit fits(logic [31:0] o, logic [31:0] n);
    return o < mips_pkg::MemBytes && n <= mips_pkg::MemBytes - o;
  endfunction

  // bytes a load would read: start offset and count; returns 0 if it faults or is no load
  function automatic bit load_span(mips_pkg::instr_t it, output logic [31:0] start,
                                   output logic [31:0] n);
    logic [31:0] ea, off, k;
    ea = rd_reg(it.src_reg) + {{16{it.immediate[15]}}, it.immediate};
    off = ea - base_q;
    k = ea & 32'd3;
    start = off;
    n = 0;
    case (it.command)
      mips_pkg::OpLb, mips_pkg::OpLbu: n = 1;
      mips_pkg::OpLh, mips_pkg::OpLhu: n = 2;
      mips_pkg::OpLw: n = 4;
      mips_pkg::OpLwl: begin
        if (off < k) return 0;
        start = off - k;
        n = k + 1;
      end
      mips_pkg::OpLwr: n = 4 - k;
      default: return 0;
    endcase
    return fits(start, n);
  endfunction

  // a load that would read never-written bytes becomes the matching store
  function automatic mips_pkg::instr_t guard_load(mips_pkg::instr_t it);
    logic [31:0] s, n;
    if (load_span(it, s, n)) begin
      for (int i = 0; i < n; i++) begin
        if (!written_q[s + i]) begin
          case (it.command)
            mips_pkg::OpLb, mips_pkg::OpLbu: it.command = mips_pkg::OpSb;
            mips_pkg::OpLh, mips_pkg::OpLhu: it.command = mips_pkg::OpSh;
            mips_pkg::OpLw: it.command = mips_pkg::OpSw;
            mips_pkg::OpLwl: it.command = mips_pkg::OpSwl;
            default: it.command = mips_pkg::OpSwr;
          endcase
          return it;
        end
      end
    end
    return it;
  endfunction

  task automatic put_byte(logic [31:0] o, logic [7:0] v);
    mem_q[o] = v;
    written_q[o] = 1;
  endtask

  task automatic execute_instr(input mips_pkg::instr_t it, output mips_pkg::result_t r);
    logic [31:0] a, b, simm, ea, off, k, npc, wval;
    logic [4:0] widx;
    logic wr;
    logic [1:0] flt;
    longint sa, sb;
    logic [63:0] prod;
    a = rd_reg(it.src_reg);
    b = rd_reg(it.second_reg);
    simm = {{16{it.immediate[15]}}, it.immediate};
    ea = a + simm;
    off = ea - base_q;
    k = ea & 32'd3;
    npc = pc_q + 32'd4;
    widx = 0; wval = 0; wr = 0; flt = mips_pkg::FaultNone;
    sa = longint'($signed(a));
    sb = longint'($signed(b));
    case (it.command)
      mips_pkg::OpAdd, mips_pkg::OpAddu: begin widx = it.dest_reg; wval = a + b; wr = 1; end
      mips_pkg::OpAnd: begin widx = it.dest_reg; wval = a & b; wr = 1; end
      mips_pkg::OpDiv: begin
        if (b == 0) flt = mips_pkg::FaultDiv;
        else begin
          lo_q = 32'(sa / sb);
          hi_q = 32'(sa % sb);
        end
      end
      mips_pkg::OpDivu: begin
        if (b == 0) flt = mips_pkg::FaultDiv;
        else begin
          lo_q = a / b;
          hi_q = a % b;
        end
      end
      mips_pkg::OpJalr: begin widx = it.dest_reg; wval = npc; wr = 1; npc = a; end
      mips_pkg::OpJr: npc = a;
      mips_pkg::OpMfhi: begin widx = it.dest_reg; wval = hi_q; wr = 1; end
      mips_pkg::OpMflo: begin widx = it.dest_reg; wval = lo_q; wr = 1; end
      mips_pkg::OpMthi: hi_q = a;
      mips_pkg::OpMtlo: lo_q = a;
      mips_pkg::OpMult: begin
        prod = 64'(sa * sb);
        hi_q = prod[63:32];
        lo_q = prod[31:0];
      end
      mips_pkg::OpMultu: begin
        prod = {32'd0, a} * {32'd0, b};
        hi_q = prod[63:32];
        lo_q = prod[31:0];
      end
      mips_pkg::OpNor: begin widx = it.dest_reg; wval = ~(a | b); wr = 1; end
      mips_pkg::OpOr: begin widx = it.dest_reg; wval = a | b; wr = 1; end
      mips_pkg::OpSll: begin widx = it.dest_reg; wval = b << it.shift_amount; wr = 1; end
      mips_pkg::OpSllv: begin widx = it.dest_reg; wval = b << a[4:0]; wr = 1; end
      mips_pkg::OpSlt: begin
        widx = it.dest_reg; wval = ($signed(a) < $signed(b)) ? 1 : 0; wr = 1;
      end
      mips_pkg::OpSltu: begin widx = it.dest_reg; wval = (a < b) ? 1 : 0; wr = 1; end
      mips_pkg::OpSra: begin
        widx = it.dest_reg; wval = $signed(b) >>> it.shift_amount; wr = 1;
      end
      mips_pkg::OpSrav: begin widx = it.dest_reg; wval = $signed(b) >>> a[4:0]; wr = 1; end
      mips_pkg::OpSrl: begin widx = it.dest_reg; wval = b >> it.shift_amount; wr = 1; end
      mips_pkg::OpSrlv: begin widx = it.dest_reg; wval = b >> a[4:0]; wr = 1; end
      mips_pkg::OpSub, mips_pkg::OpSubu: begin widx = it.dest_reg; wval = a - b; wr = 1; end
      mips_pkg::OpXor: begin widx = it.dest_reg; wval = a ^ b; wr = 1; end
      mips_pkg::OpAddi, mips_pkg::OpAddiu: begin
        widx = it.second_reg; wval = a + simm; wr = 1;
      end
      mips_pkg::OpAndi: begin
        widx = it.second_reg; wval = a & {16'd0, it.immediate}; wr = 1;
      end
      mips_pkg::OpBeq: if (a == b) npc += simm << 2;
      mips_pkg::OpBgez: if (!a[31]) npc += simm << 2;
      mips_pkg::OpBgtz: if (!a[31] && a != 0) npc += simm << 2;
      mips_pkg::OpBlez: if (a[31] || a == 0) npc += simm << 2;
      mips_pkg::OpBltz: if (a[31]) npc += simm << 2;
      mips_pkg::OpBne: if (a != b) npc += simm << 2;
      mips_pkg::OpLb, mips_pkg::OpLbu: begin
        if (!fits(off, 1)) flt = mips_pkg::FaultAddr;
        else begin
          wval = {24'd0, mem_q[off]};
          if (it.command == mips_pkg::OpLb) wval = {{24{wval[7]}}, wval[7:0]};
          widx = it.second_reg; wr = 1;
        end
      end
      mips_pkg::OpLh, mips_pkg::OpLhu: begin
        if (!fits(off, 2)) flt = mips_pkg::FaultAddr;
        else begin
          wval = {16'd0, mem_q[off + 1], mem_q[off]};
          if (it.command == mips_pkg::OpLh) wval = {{16{wval[15]}}, wval[15:0]};
          widx = it.second_reg; wr = 1;
        end
      end
      mips_pkg::OpLui: begin widx = it.second_reg; wval = {it.immediate, 16'd0}; wr = 1; end
      mips_pkg::OpLw: begin
        if (!fits(off, 4)) flt = mips_pkg::FaultAddr;
        else begin
          wval = {mem_q[off + 3], mem_q[off + 2], mem_q[off + 1], mem_q[off]};
          widx = it.second_reg; wr = 1;
        end
      end
      mips_pkg::OpOri: begin
        widx = it.second_reg; wval = a | {16'd0, it.immediate}; wr = 1;
      end
      mips_pkg::OpSb: begin
        if (!fits(off, 1)) flt = mips_pkg::FaultAddr;
        else put_byte(off, b[7:0]);
      end
      mips_pkg::OpSlti: begin
        widx = it.second_reg; wval = ($signed(a) < $signed(simm)) ? 1 : 0; wr = 1;
      end
      mips_pkg::OpSltiu: begin widx = it.second_reg; wval = (a < simm) ? 1 : 0; wr = 1; end
      mips_pkg::OpSh: begin
        if (!fits(off, 2)) flt = mips_pkg::FaultAddr;
        else for (int i = 0; i < 2; i++) put_byte(off + i, b[8*i +: 8]);
      end
      mips_pkg::OpSw: begin
        if (!fits(off, 4)) flt = mips_pkg::FaultAddr;
        else for (int i = 0; i < 4; i++) put_byte(off + i, b[8*i +: 8]);
      end
      mips_pkg::OpXori: begin
        widx = it.second_reg; wval = a ^ {16'd0, it.immediate}; wr = 1;
      end
      mips_pkg::OpLwl, mips_pkg::OpSwl: begin
        if (off < k || !fits(off - k, k + 1)) flt = mips_pkg::FaultAddr;
        else begin
          wval = b;
          for (int i = 0; i <= k; i++) begin
            if (it.command == mips_pkg::OpLwl) wval[8*(3-i) +: 8] = mem_q[off - i];
            else put_byte(off - i, b[8*(3-i) +: 8]);
          end
          if (it.command == mips_pkg::OpLwl) begin widx = it.second_reg; wr = 1; end
        end
      end
      mips_pkg::OpLwr, mips_pkg::OpSwr: begin
        if (!fits(off, 4 - k)) flt = mips_pkg::FaultAddr;
        else begin
          wval = b;
          for (int i = 0; i < 4 - k; i++) begin
            if (it.command == mips_pkg::OpLwr) wval[8*i +: 8] = mem_q[off + i];
            else put_byte(off + i, b[8*i +: 8]);
          end
          if (it.command == mips_pkg::OpLwr) begin widx = it.second_reg; wr = 1; end
        end
      end
      mips_pkg::OpJ: npc = (npc & mips_pkg::SegMask) | {4'd0, it.jump_target, 2'b00};
      mips_pkg::OpJal: begin
        widx = 5'd31; wval = npc; wr = 1;
        npc = (npc & mips_pkg::SegMask) | {4'd0, it.jump_target, 2'b00};
      end
      default: ;
    endcase
    if (!wr || flt != mips_pkg::FaultNone || widx == 0) begin
      wr = 0; widx = 0; wval = 0;
    end else begin
      gpr[widx] = wval;
    end
    pc_q = npc;
    r = '{npc, widx, wval, wr, hi_q, lo_q, flt};
  endtask

  task automatic send_request(input mips_pkg::instr_t it);
    mips_pkg::result_t r;
    it = guard_load(it);
    execute_instr(it, r);
    pending_results = {pending_results, r};
    if (!calm && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    data_i <= it;
    push <= 1'b1;
    do @(posedge clk_i); while (full);
  endtask

  function automatic mips_pkg::instr_t mk(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [15:0] imm);
    return '{op, rs, rt, rd, 5'($urandom), imm, 26'($urandom)};
  endfunction

  function automatic mips_pkg::instr_t random_instr();
    mips_pkg::instr_t it;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    it = raw[67:0];
    it.command = 6'($urandom_range(0, 63));
    return it;
  endfunction

  // memory request at a given offset from the base, via a pointer register if needed
  task automatic mem_request(logic [5:0] op, logic [31:0] off, logic [4:0] rt);
    logic [31:0] ea, diff;
    logic [4:0] rs;
    int start;
    bit found;
    ea = base_q + off;
    start = $urandom_range(0, 31);
    found = 0;
    for (int i = 0; i < 32 && !found; i++) begin
      rs = 5'(start + i);
      diff = ea - rd_reg(rs);
      if (diff + 32'h8000 < 32'h10000) found = 1;
    end
    if (!found) begin
      send_request(mk(mips_pkg::OpLui, 0, PtrReg, 0, ea[31:16]));
      send_request(mk(mips_pkg::OpOri, PtrReg, PtrReg, 0, ea[15:0]));
      rs = PtrReg;
      diff = ea - rd_reg(rs);
    end
    send_request(mk(op, rs, rt, 5'($urandom), diff[15:0]));
  endtask

  task automatic set_base(logic [31:0] v);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_data_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    base_q = v;
    pc_q = v;
  endtask

  task automatic report_field(string f, logic [31:0] e, logic [31:0] a);
    if (e !== a) begin
      $display("%0t mismatch %s: expected %h actual %h", $time, f, e, a);
      errors++;
    end
  endtask

  always @(posedge clk_i) begin
    mips_pkg::result_t e;
    if (rst_ni && pop && !empty) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, data_o);
        errors++;
      end else begin
        e = pending_results.pop_front();
        report_field("next_pc", e.next_pc, data_o.next_pc);
        report_field("written_index", 32'(e.written_index), 32'(data_o.written_index));
        report_field("written_value", e.written_value, data_o.written_value);
        report_field("did_write", 32'(e.did_write), 32'(data_o.did_write));
        report_field("hi_value", e.hi_value, data_o.hi_value);
        report_field("lo_value", e.lo_value, data_o.lo_value);
        report_field("fault", 32'(e.fault), 32'(data_o.fault));
      end
    end
  end

  initial begin
    pop <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      pop <= 1'b1;
      @(posedge clk_i);
    end
  end

  task automatic test_alu_extremes();
    send_request(mk(mips_pkg::OpLui, 0, 1, 0, 16'h8000));
    send_request(mk(mips_pkg::OpAddiu, 0, 2, 0, 16'hffff));
    send_request(mk(mips_pkg::OpOri, 0, 3, 0, 16'hffff));
    send_request(mk(mips_pkg::OpAdd, 1, 2, 0, 0));        // write to register zero dropped
    send_request(mk(mips_pkg::OpSlt, 1, 2, 4, 0));
    send_request(mk(mips_pkg::OpSltu, 1, 2, 5, 0));
    send_request(mk(mips_pkg::OpSrav, 2, 1, 6, 0));       // shift uses low 5 bits only
    send_request(mk(mips_pkg::OpMult, 1, 2, 0, 0));
    send_request(mk(mips_pkg::OpMultu, 2, 2, 0, 0));
    send_request(mk(mips_pkg::OpMfhi, 0, 0, 7, 0));
    send_request(mk(mips_pkg::OpMtlo, 3, 0, 0, 0));
  endtask

  task automatic test_divide();
    send_request(mk(mips_pkg::OpDiv, 1, 2, 0, 0));        // most negative over minus one
    send_request(mk(mips_pkg::OpDiv, 1, 0, 0, 0));
    send_request(mk(mips_pkg::OpDivu, 2, 3, 0, 0));
    send_request(mk(mips_pkg::OpDivu, 3, 0, 0, 0));
  endtask

  task automatic test_memory();
    mem_request(mips_pkg::OpSw, 0, 2);
    mem_request(mips_pkg::OpLwl, 2, 8);
    mem_request(mips_pkg::OpSwr, 5, 1);
    mem_request(mips_pkg::OpLwr, 5, 9);
    mem_request(mips_pkg::OpLb, 3, 10);
    mem_request(mips_pkg::OpSh, mips_pkg::MemBytes - 2, 3);
    mem_request(mips_pkg::OpLh, mips_pkg::MemBytes - 2, 11);
    mem_request(mips_pkg::OpLw, mips_pkg::MemBytes - 2, 12);   // runs past the end
    mem_request(mips_pkg::OpSwl, 32'hffff_fffe, 3);            // below the base
  endtask

  task automatic test_control();
    send_request(mk(mips_pkg::OpBeq, 0, 0, 0, 16'hffff));
    send_request(mk(mips_pkg::OpBltz, 1, 0, 0, 16'h7fff));
    send_request('{mips_pkg::OpJal, 5'd0, 5'd0, 5'd0, 5'd0, 16'd0, 26'h3ff_ffff});
    send_request(mk(mips_pkg::OpJalr, 31, 0, 13, 0));
    send_request(mk(6'd63, 0, 0, 0, 0));        // unknown code
  endtask

  task automatic test_random(int n, bit finale);
    for (int i = 0; i < n; i++) begin
      if (finale && i == n - 100 && n >= 100) calm = 1;
      if ($urandom_range(0, 99) < 40) begin
        logic [5:0] op;
        logic [31:0] off;
        case ($urandom_range(0, 11))
          0: op = mips_pkg::OpLb; 1: op = mips_pkg::OpLbu;
          2: op = mips_pkg::OpLh; 3: op = mips_pkg::OpLhu;
          4: op = mips_pkg::OpLw; 5: op = mips_pkg::OpLwl;
          6: op = mips_pkg::OpLwr; 7: op = mips_pkg::OpSb;
          8: op = mips_pkg::OpSh; 9: op = mips_pkg::OpSw;
          10: op = mips_pkg::OpSwl; default: op = mips_pkg::OpSwr;
        endcase
        if ($urandom_range(0, 7) == 0) off = mips_pkg::MemBytes - 8 + $urandom_range(0, 11);
        else off = $urandom_range(0, 63);
        mem_request(op, off, 5'($urandom));
      end else begin
        send_request(random_instr());
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    push <= 1'b0;
    data_i <= '0;
    cfg_we_i <= 1'b0;
    cfg_data_i <= '0;
    for (int i = 0; i < 32; i++) gpr[i] = 0;
    for (int i = 0; i < mips_pkg::MemBytes; i++) written_q[i] = 0;
    hi_q = 0; lo_q = 0;
    base_q = mips_pkg::BaseReset; pc_q = mips_pkg::BaseReset;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_alu_extremes();
    test_divide();
    test_memory();
    test_control();
    test_random(140, 1'b0);
    set_base(32'h0000_0000);
    test_random(140, 1'b0);
    set_base(32'hffff_ffff);
    test_memory();
    test_random(140, 1'b0);
    set_base($urandom);
    test_random(160, 1'b1);
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/mips_pkg.sv
sv/mips_inq.sv
sv/mips_div.sv
sv/mips_exec.sv
sv/mips_integer_execute_unit_core.sv
test/mips_integer_execute_unit_core_tb.sv
